// ===== hw/rtl/vlt_pkg.sv =====
// Shared types, constants and reset table for the video line timer register block.
package vlt_pkg;

	localparam int REG_WORDS_DFLT = 14;
	localparam int FRAME_LINES_DFLT = 525;

	localparam int WORD_IDX_W = 4;
	localparam int LINE_W = 10;
	localparam int ACC_W = 17;
	localparam int CPL_W = 16;
	localparam int CPL_RESET = 2976;

	localparam logic [WORD_IDX_W-1:0] W_VINTR = 4'd3;
	localparam logic [WORD_IDX_W-1:0] W_VCURRENT = 4'd4;
	localparam logic [WORD_IDX_W-1:0] W_VSYNC = 4'd6;

	localparam logic [LINE_W-1:0] LINE_MASK = 10'h3FE;
	localparam logic [LINE_W-1:0] FRAME_LINES_MIN = 10'd100;
	localparam logic [LINE_W-1:0] FRAME_LINES_MAX = 10'd799;

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_RESP
	} state_t;

	// Timing words the register file hands to the line stepper
	typedef struct packed {
		logic [LINE_W-1:0] vintr_line;
		logic [LINE_W-1:0] frame_lines;
	} timing_t;

	function automatic logic [31:0] reg_reset_word(input logic [WORD_IDX_W-1:0] idx);
		logic [31:0] w;
		case (idx)
			4'd0: w = 32'h0000_3202;
			4'd2: w = 32'd320;
			4'd3: w = 32'h0000_0002;
			4'd5: w = 32'h03E5_2239;
			4'd6: w = 32'h0000_020D;
			4'd7: w = 32'h0000_0C15;
			4'd8: w = 32'h0C15_0C15;
			4'd9: w = 32'h006C_02EC;
			4'd10: w = 32'h0025_01FF;
			4'd11: w = 32'h000E_0204;
			4'd12: w = 32'h0000_0200;
			4'd13: w = 32'h0000_0400;
			default: w = 32'h0000_0000;
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/vlt_regs.sv =====
// Register file words, bus read mux and vsync frame length decode.
module vlt_regs import vlt_pkg::*; #(
	parameter int REG_WORDS = REG_WORDS_DFLT,
	parameter int DEFAULT_FRAME_LINES = FRAME_LINES_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [WORD_IDX_W-1:0] idx,
	input  logic [31:0]           wr_data,
	output logic [31:0]           rd_word,
	output timing_t               timing
);

	logic [31:0]       words_q [REG_WORDS];
	logic [LINE_W-1:0] frame_lines_q;
	logic              idx_valid;
	logic [LINE_W-1:0] vs_lines;

	assign idx_valid = {1'b0, idx} < 5'(REG_WORDS);
	assign vs_lines = wr_data[LINE_W-1:0];

	// current-line word lives in the stepper; its slot here is never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_WORDS; i++) begin
				words_q[i] <= reg_reset_word(WORD_IDX_W'(i));
			end
			frame_lines_q <= LINE_W'(DEFAULT_FRAME_LINES);
		end else if (wr_en && idx_valid && idx != W_VCURRENT) begin
			words_q[idx] <= wr_data;
			if (idx == W_VSYNC && vs_lines inside {[FRAME_LINES_MIN:FRAME_LINES_MAX]}) begin
				frame_lines_q <= vs_lines;
			end
		end
	end

	always_comb begin
		rd_word = '0;
		if (idx_valid) begin
			rd_word = words_q[idx];
		end
	end

	assign timing.vintr_line = words_q[W_VINTR][LINE_W-1:0] & LINE_MASK;
	assign timing.frame_lines = frame_lines_q;

endmodule

// ===== hw/rtl/video_line_timer_registers.sv =====
// Video line timer register block: bus register file, scan line stepper and interrupt.
//
// Every item (register read, register write or tick) is taken when the block is
// idle and gives one result. A read or write has the transfer cycle, where the
// bus access is done, and a result cycle that loads the output register. A tick
// that changes nothing (tick_cycles zero, or cycles_per_line zero) goes the same way.
// Any other tick adds to the cycle accumulator in the transfer; one shared
// add/compare/subtract unit then retires one line per cycle and steps the
// half-line counter until a cycle finds no line due, and the result cycle
// follows. The result cycle waits while the output register still holds an
// untaken result. s_tready is low from the transfer until the result is loaded;
// the output register holds a result until m_tready takes it.
module video_line_timer_registers import vlt_pkg::*; #(
	parameter int REG_WORDS = REG_WORDS_DFLT,
	parameter int DEFAULT_FRAME_LINES = FRAME_LINES_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // reg_offset[5:0], write_data[37:6], tick_cycles[53:38], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // read_data[31:0], interrupt_level[32],
	                               // current_half_line[42:33], frames_done[74:43], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // cycles_per_line
);

	state_t state_q, state_d;

	logic [CPL_W-1:0]      cpl_q;
	logic [ACC_W-1:0]      acc_q;
	logic [LINE_W-1:0]     line_q;
	logic [31:0]           frames_q;
	logic                  irq_q;
	logic [31:0]           rd_q;
	logic                  m_tvalid_q;
	logic [79:0]           m_tdata_q;

	op_t                   op;
	logic [WORD_IDX_W-1:0] idx;
	logic [31:0]           wdata;
	logic [CPL_W-1:0]      tick_cycles;
	logic                  take;
	logic                  tick_go;
	logic                  line_due;
	logic                  do_step;
	logic                  out_free;
	logic                  load_out;
	logic                  reg_wr;
	logic [31:0]           rd_word;
	timing_t               timing;

	logic [LINE_W-1:0]     line_next;
	logic                  wrap;

	assign op = op_t'(s_tuser);
	assign idx = s_tdata[5:2];
	assign wdata = s_tdata[37:6];
	assign tick_cycles = s_tdata[53:38];

	assign tick_go = op == OP_TICK && tick_cycles != '0 && cpl_q != '0;
	assign line_due = acc_q >= {1'b0, cpl_q};
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	vlt_regs #(
		.REG_WORDS(REG_WORDS),
		.DEFAULT_FRAME_LINES(DEFAULT_FRAME_LINES)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(reg_wr),
		.idx(idx),
		.wr_data(wdata),
		.rd_word(rd_word),
		.timing(timing)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = tick_go ? ST_STEP : ST_RESP;
				end
			end
			ST_STEP: begin
				if (!line_due) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		do_step = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_STEP: do_step = line_due;
			ST_RESP: load_out = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	assign take = s_tready && s_tvalid;
	assign reg_wr = take && op == OP_WRITE;

	// one line of the stepper: advance by a half-line pair, wrap past frame end
	always_comb begin
		line_next = (line_q + LINE_W'(2)) & LINE_MASK;
		wrap = line_next > (timing.frame_lines & LINE_MASK) || line_next == '0;
		if (wrap) begin
			line_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cpl_q <= CPL_W'(CPL_RESET);
			acc_q <= '0;
			line_q <= '0;
			frames_q <= '0;
			irq_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cpl_q <= cfg_data;
			end
			if (take) begin
				case (op)
					OP_WRITE: begin
						if (idx == W_VCURRENT) begin
							irq_q <= 1'b0;
						end
					end
					OP_TICK: begin
						if (tick_go) begin
							acc_q <= acc_q + ACC_W'(tick_cycles);
						end
					end
					default: ;
				endcase
			end
			if (do_step) begin
				acc_q <= acc_q - ACC_W'(cpl_q);
				line_q <= line_next;
				if (wrap) begin
					frames_q <= frames_q + 32'd1;
					irq_q <= 1'b0;
				end else if (!irq_q && timing.vintr_line != '0
					&& line_next == timing.vintr_line) begin
					irq_q <= 1'b1;
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (op == OP_READ) begin
				rd_q <= (idx == W_VCURRENT) ? 32'(line_q) : rd_word;
			end else begin
				rd_q <= '0;
			end
		end
		if (load_out) begin
			m_tdata_q <= {5'b0, frames_q, line_q, irq_q, rd_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// ===== hw/rtl/vlt_checker.sv =====
// Port-level checker for the video line timer register block, bound to the top level.
module vlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: no transfer directly after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// half-line counter only holds even values
	a_even_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[33])
		else $error("odd half-line");

	// interrupt cannot be up on line zero: every wrap re-arms it
	a_irq_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[42:33] != 10'd0)
		else $error("interrupt high on line zero");

endmodule

bind video_line_timer_registers vlt_checker u_vlt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== verif/tb_top.sv =====
// Testbench for the video line timer register block: directed and random bus/tick traffic.
module tb_top;
	import vlt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 200000;
	localparam int ITEMS_PER_SETTING = 335;
	localparam int REPORT_MAX = 50;

	// frames_done down to read_data, so the packed layout matches m_tdata[74:0]
	typedef struct packed {
		logic [31:0] frames;
		logic [9:0]  half_line;
		logic        irq;
		logic [31:0] read_data;
	} line_status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // reg_offset[5:0], write_data[37:6], tick_cycles[53:38], zero pad
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;   // read_data[31:0], interrupt_level[32],
	                        // current_half_line[42:33], frames_done[74:43], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;  // cycles_per_line

	// Predicted state of the block
	logic [31:0] vt_regs [0:15];
	logic [31:0] cycle_acc;
	logic [9:0]  frame_len;
	logic [31:0] frame_count;
	logic        irq_level;
	logic [15:0] line_period;

	line_status_t expected_status [$];
	line_status_t got_status;
	line_status_t want_status;
	int mismatch_count = 0;
	int stall_cycles = 0;
	int src_idle_pct;
	int dst_idle_pct;

	video_line_timer_registers u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// Status after one item; updates the predicted state
	function automatic line_status_t next_line_status(input logic [1:0] op,
			input logic [5:0] off, input logic [31:0] wdata, input logic [15:0] ticks);
		line_status_t st;
		logic [3:0] idx;
		logic [9:0] nxt;
		logic [9:0] tgt;
		st = '0;
		idx = off[5:2];
		case (op)
			OP_READ: begin
				if (idx < REG_WORDS_DFLT)
					st.read_data = vt_regs[idx];
			end
			OP_WRITE: begin
				if (idx < REG_WORDS_DFLT) begin
					if (idx == W_VCURRENT) begin
						irq_level = 1'b0;
					end else begin
						vt_regs[idx] = wdata;
						if (idx == W_VSYNC && wdata[9:0] >= FRAME_LINES_MIN &&
								wdata[9:0] <= FRAME_LINES_MAX)
							frame_len = wdata[9:0];
					end
				end
			end
			OP_TICK: begin
				if (ticks != 16'd0 && line_period != 16'd0) begin
					cycle_acc = cycle_acc + 32'(ticks);
					while (cycle_acc >= 32'(line_period)) begin
						cycle_acc = cycle_acc - 32'(line_period);
						nxt = (vt_regs[W_VCURRENT][9:0] + 10'd2) & LINE_MASK;
						// past the frame end: wrap and re-arm
						if (nxt > (frame_len & LINE_MASK) || nxt == 10'd0) begin
							nxt = 10'd0;
							frame_count = frame_count + 32'd1;
							irq_level = 1'b0;
						end
						vt_regs[W_VCURRENT] = {22'd0, nxt};
						tgt = vt_regs[W_VINTR][9:0] & LINE_MASK;
						if (!irq_level && tgt != 10'd0 && nxt == tgt)
							irq_level = 1'b1;
					end
				end
			end
			default: ;
		endcase
		st.irq = irq_level;
		st.half_line = vt_regs[W_VCURRENT][9:0];
		st.frames = frame_count;
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < REPORT_MAX)
			$display("mismatch on %s: got %h, want %h", what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_status = m_tdata[74:0];
			if (expected_status.size() == 0) begin
				report_mismatch("result with nothing pending", got_status.read_data, 32'd0);
			end else begin
				want_status = expected_status.pop_front();
				if (got_status.read_data !== want_status.read_data)
					report_mismatch("read_data", got_status.read_data, want_status.read_data);
				if (got_status.irq !== want_status.irq)
					report_mismatch("interrupt_level", 32'(got_status.irq),
						32'(want_status.irq));
				if (got_status.half_line !== want_status.half_line)
					report_mismatch("current_half_line", 32'(got_status.half_line),
						32'(want_status.half_line));
				if (got_status.frames !== want_status.frames)
					report_mismatch("frames_done", got_status.frames, want_status.frames);
			end
		end
	end

	// Watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic issue_bus_item(input logic [1:0] op, input logic [5:0] off,
			input logic [31:0] wdata, input logic [15:0] ticks);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, ticks, wdata, off};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_status.push_back(next_line_status(op, off, wdata, ticks));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_line_period(input logic [15:0] cpl);
		cfg_valid <= 1'b1;
		cfg_data <= cpl;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		line_period = cpl;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_item();
		logic [1:0] op;
		logic [5:0] off;
		logic [31:0] wdata;
		logic [15:0] ticks;
		int pick;
		int sel;
		int hi;
		pick = $urandom_range(0, 99);
		off = 6'($urandom_range(0, 63));
		wdata = $urandom();
		hi = 2 * int'(line_period);
		if (hi > 65535)
			hi = 65535;
		// mostly about one line per tick; now and then a long burst
		if (line_period == 16'd0 || (line_period >= 16'd256 && $urandom_range(0, 19) == 0))
			ticks = 16'($urandom_range(0, 65535));
		else
			ticks = 16'($urandom_range(0, hi));
		if (pick < 45) begin
			op = OP_TICK;
		end else if (pick < 70) begin
			op = OP_READ;
		end else if (pick < 95) begin
			op = OP_WRITE;
			sel = $urandom_range(0, 9);
			if (sel < 3) begin
				off = {W_VINTR, off[1:0]};
				if ($urandom_range(0, 9) < 7)
					wdata[9:0] = 10'($urandom_range(1, int'(frame_len & LINE_MASK) / 2) * 2);
			end else if (sel < 5) begin
				off = {W_VSYNC, off[1:0]};
				if ($urandom_range(0, 3) != 0)
					wdata[9:0] = 10'($urandom_range(100, 220));
			end else if (sel < 7) begin
				off = {W_VCURRENT, off[1:0]};
			end
		end else begin
			op = OP_UNUSED;
		end
		issue_bus_item(op, off, wdata, ticks);
	endtask

	// Reset words, words past the end, current-line and vsync writes, unused opcode
	task automatic test_register_access();
		issue_bus_item(OP_READ, 6'h00, 32'd0, 16'd0);
		issue_bus_item(OP_READ, 6'h14, 32'd0, 16'd0);
		issue_bus_item(OP_READ, 6'h23, 32'd0, 16'd0);
		issue_bus_item(OP_READ, 6'h34, 32'd0, 16'd0);
		issue_bus_item(OP_READ, 6'h38, 32'd0, 16'd0);
		issue_bus_item(OP_READ, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
		issue_bus_item(OP_WRITE, 6'h38, 32'hFFFF_FFFF, 16'd0);
		issue_bus_item(OP_READ, 6'h38, 32'd0, 16'd0);
		issue_bus_item(OP_WRITE, 6'h10, 32'hFFFF_FFFF, 16'd0);
		issue_bus_item(OP_WRITE, 6'h18, 32'h0000_0063, 16'd0);
		issue_bus_item(OP_WRITE, 6'h18, 32'h0000_0320, 16'd0);
		issue_bus_item(OP_WRITE, 6'h18, 32'hFFFF_FF1F, 16'd0);
		issue_bus_item(OP_WRITE, 6'h18, 32'hFFFF_FC64, 16'd0);
		issue_bus_item(OP_READ, 6'h18, 32'd0, 16'd0);
		issue_bus_item(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	// Line steps, interrupt raise and clear, frame wrap with re-arm
	task automatic test_line_stepping();
		issue_bus_item(OP_WRITE, 6'h0C, 32'h0000_0004, 16'd0);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'd0);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'd2976);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'd2976);
		issue_bus_item(OP_WRITE, 6'h10, 32'h0000_0000, 16'd0);
		issue_bus_item(OP_READ, 6'h10, 32'd0, 16'd0);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'hFFFF);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'hFFFF);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'hFFFF);
	endtask

	// Stopped stepping, shortest lines, longest lines, period lowered under the accumulator
	task automatic test_line_period_extremes();
		wait_idle();
		set_line_period(16'd0);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'hFFFF);
		wait_idle();
		set_line_period(16'd1);
		issue_bus_item(OP_TICK, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
		wait_idle();
		set_line_period(16'hFFFF);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'd65000);
		wait_idle();
		set_line_period(16'd7);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'd1);
		wait_idle();
		set_line_period(16'hFFFF);
		issue_bus_item(OP_TICK, 6'h00, 32'd0, 16'hFFFF);
	endtask

	task automatic test_random_traffic(input int src_pct, input int dst_pct,
			input logic [15:0] cpl_a, input logic [15:0] cpl_b);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
		wait_idle();
		set_line_period(cpl_a);
		repeat (ITEMS_PER_SETTING) random_item();
		wait_idle();
		set_line_period(cpl_b);
		repeat (ITEMS_PER_SETTING) random_item();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		src_idle_pct = 29;
		dst_idle_pct = 73;

		for (int i = 0; i < 16; i++)
			vt_regs[i] = 32'd0;
		vt_regs[0] = 32'h0000_3202;
		vt_regs[2] = 32'd320;
		vt_regs[3] = 32'h0000_0002;
		vt_regs[5] = 32'h03E5_2239;
		vt_regs[6] = 32'h0000_020D;
		vt_regs[7] = 32'h0000_0C15;
		vt_regs[8] = 32'h0C15_0C15;
		vt_regs[9] = 32'h006C_02EC;
		vt_regs[10] = 32'h0025_01FF;
		vt_regs[11] = 32'h000E_0204;
		vt_regs[12] = 32'h0000_0200;
		vt_regs[13] = 32'h0000_0400;
		cycle_acc = 32'd0;
		frame_len = 10'(FRAME_LINES_DFLT);
		frame_count = 32'd0;
		irq_level = 1'b0;
		line_period = 16'(CPL_RESET);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_access();
		test_line_stepping();
		test_line_period_extremes();
		test_random_traffic(29, 73, 16'd2976, 16'd13);
		test_random_traffic(73, 29, 16'd1, 16'hFFFF);
		test_random_traffic(0, 0, 16'd0, 16'($urandom_range(2, 600)));

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
